>>> rtl/rpn_pkg.sv
// types and codes shared by the postfix evaluation stack
package rpn_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned CmdW    = 3;
  localparam int unsigned DepthW  = 7;
  localparam int unsigned StatusW = 2;

  localparam logic [CmdW-1:0] CMD_PUSH    = 3'd0;
  localparam logic [CmdW-1:0] CMD_ADD     = 3'd1;
  localparam logic [CmdW-1:0] CMD_SUB     = 3'd2;
  localparam logic [CmdW-1:0] CMD_MUL     = 3'd3;
  localparam logic [CmdW-1:0] CMD_DIV     = 3'd4;
  localparam logic [CmdW-1:0] CMD_DISCARD = 3'd5;

  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [StatusW-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [StatusW-1:0] ST_DIVZERO   = 2'd3;

  typedef struct packed {
    logic [CmdW-1:0]         command;
    logic signed [DataW-1:0] push_value;
  } rpn_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] top_value;
    logic [DepthW-1:0]       depth;
    logic [StatusW-1:0]      status;
  } rpn_out_t;

  typedef struct packed {
    logic start;
    logic done;
  } rpn_div_ctl_t;

endpackage

>>> rtl/rpn_ram.sv
// generic single write port memory with registered read
module rpn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/rpn_div.sv
// iterative signed divider, one quotient bit per cycle, truncating
module rpn_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rpn_pkg::rpn_div_ctl_t           ctl_i,
  output rpn_pkg::rpn_div_ctl_t           ctl_o,
  input  logic signed [rpn_pkg::DataW-1:0] dividend_i,
  input  logic signed [rpn_pkg::DataW-1:0] divisor_i,
  output logic signed [rpn_pkg::DataW-1:0] quotient_o
);
  import rpn_pkg::*;

  localparam int unsigned CntW = $clog2(DataW);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [DataW:0]  rem_q;
  logic [DataW-1:0] quot_q;
  logic [DataW-1:0] mb_q;
  logic            neg_q;

  logic [DataW:0]   rem_sh;
  logic [DataW:0]   diff;
  logic [DataW-1:0] ma;
  logic [DataW-1:0] mb;

  assign ma     = dividend_i[DataW-1] ? (DataW'(0) - dividend_i) : dividend_i;
  assign mb     = divisor_i[DataW-1] ? (DataW'(0) - divisor_i) : divisor_i;
  assign rem_sh = {rem_q[DataW-1:0], quot_q[DataW-1]};
  assign diff   = rem_sh - {1'b0, mb_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(DataW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // restoring step on magnitudes, sign applied at the end
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      rem_q  <= '0;
      quot_q <= ma;
      mb_q   <= mb;
      neg_q  <= dividend_i[DataW-1] ^ divisor_i[DataW-1];
    end else if (busy_q) begin
      if (!diff[DataW]) begin
        rem_q  <= diff;
        quot_q <= {quot_q[DataW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        quot_q <= {quot_q[DataW-2:0], 1'b0};
      end
    end
  end

  assign quotient_o  = neg_q ? (DataW'(0) - quot_q) : quot_q;
  assign ctl_o.done  = done_q;
  assign ctl_o.start = busy_q;

endmodule

>>> rtl/rpn_stack_calculator_top.sv
// postfix evaluation stack: memory-held entries, cached top, sequencer
// A word is taken when start is high and busy is low; exactly one result word follows,
// shown for one cycle with done_o high, and it cannot be held off. A push or any
// rejected command (overflow, underflow, unused code) answers in the cycle after it
// is taken; add, subtract, multiply and discard go through stack memory read,
// operate and write back; divide runs the divider, which produces one quotient bit
// per cycle, between operate and write back, except that a zero divisor is reported
// from the operate step with no division run. Entries live in a STACK_DEPTH x 32
// memory with one write and one registered read port; the top entry is also kept
// in a register so a binary operation needs only one memory read. The memory needs
// no clearing, only entries below the count are ever read.
module rpn_stack_calculator_top #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  rpn_pkg::rpn_in_t  in_i,
  output logic              done_o,
  output rpn_pkg::rpn_out_t result_o
);
  import rpn_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_WRITE
  } state_e;

  state_e              state_q;
  logic [CW-1:0]       count_q;
  logic [DataW-1:0]    top_q;
  logic [DataW-1:0]    r_q;
  logic [CmdW-1:0]     cmd_q;
  logic                done_q;
  rpn_out_t            res_q;

  logic                accept;
  logic                full;
  logic                is_op;
  logic [AW-1:0]       cnt_addr;
  logic [AW-1:0]       below_addr;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [DataW-1:0]    ram_wdata;
  logic                ram_re;
  logic [DataW-1:0]    op1;
  logic [DataW-1:0]    top_or_zero;
  rpn_div_ctl_t        div_in;
  rpn_div_ctl_t        div_out;
  logic signed [DataW-1:0] div_q;

  assign accept      = start && !busy;
  assign full        = count_q >= CW'(STACK_DEPTH);
  assign is_op       = (in_i.command >= CMD_ADD) && (in_i.command <= CMD_DISCARD);
  assign cnt_addr    = count_q[AW-1:0];
  assign below_addr  = cnt_addr - AW'(2);
  assign top_or_zero = (count_q == '0) ? '0 : top_q;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_addr;
    ram_wdata = in_i.push_value;
    if (state_q == S_WRITE) begin
      ram_we    = 1'b1;
      ram_waddr = below_addr;
      ram_wdata = r_q;
    end else if (accept && (in_i.command == CMD_PUSH) && !full) begin
      ram_we = 1'b1;
    end
  end

  assign ram_re = accept && is_op;

  rpn_ram #(
    .WIDTH(DataW),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(below_addr),
    .rdata_o(op1)
  );

  assign div_in.start = (state_q == S_EXEC) && (cmd_q == CMD_DIV) && (top_q != '0);
  assign div_in.done  = 1'b0;

  rpn_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (div_in),
    .ctl_o     (div_out),
    .dividend_i(op1),
    .divisor_i (top_q),
    .quotient_o(div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
      top_q   <= '0;
      r_q     <= '0;
      cmd_q   <= CMD_PUSH;
      res_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (in_i.command == CMD_PUSH) begin
              done_q <= 1'b1;
              if (full) begin
                res_q.top_value <= top_or_zero;
                res_q.depth     <= DepthW'(count_q);
                res_q.status    <= ST_OVERFLOW;
              end else begin
                count_q         <= count_q + CW'(1);
                top_q           <= in_i.push_value;
                res_q.top_value <= in_i.push_value;
                res_q.depth     <= DepthW'(count_q + CW'(1));
                res_q.status    <= ST_OK;
              end
            end else if (is_op) begin
              if (count_q < CW'(2)) begin
                done_q          <= 1'b1;
                res_q.top_value <= top_or_zero;
                res_q.depth     <= DepthW'(count_q);
                res_q.status    <= ST_UNDERFLOW;
              end else begin
                cmd_q   <= in_i.command;
                state_q <= S_EXEC;
              end
            end else begin
              // unused codes report the stack unchanged
              done_q          <= 1'b1;
              res_q.top_value <= top_or_zero;
              res_q.depth     <= DepthW'(count_q);
              res_q.status    <= ST_OK;
            end
          end
        end
        S_EXEC: begin
          state_q <= S_WRITE;
          case (cmd_q)
            CMD_ADD: r_q <= op1 + top_q;
            CMD_SUB: r_q <= op1 - top_q;
            CMD_MUL: r_q <= DataW'(op1 * top_q);
            CMD_DIV: begin
              if (top_q == '0) begin
                done_q          <= 1'b1;
                res_q.top_value <= top_q;
                res_q.depth     <= DepthW'(count_q);
                res_q.status    <= ST_DIVZERO;
                state_q         <= S_IDLE;
              end else begin
                state_q <= S_DIV;
              end
            end
            default: r_q <= op1;
          endcase
        end
        S_DIV: begin
          if (div_out.done) begin
            r_q     <= div_q;
            state_q <= S_WRITE;
          end
        end
        S_WRITE: begin
          count_q         <= count_q - CW'(1);
          top_q           <= r_q;
          done_q          <= 1'b1;
          res_q.top_value <= r_q;
          res_q.depth     <= DepthW'(count_q - CW'(1));
          res_q.status    <= ST_OK;
          state_q         <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
